[hdl/smpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg
// Types and codes shared by the stable minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  // Operation codes carried in the func field.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned FILL_W = 5;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] in_data;
    logic [PRIO_W-1:0]        in_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_data;
    logic [PRIO_W-1:0]        out_priority;
    logic [1:0]               status;
    logic [FILL_W-1:0]        fill_count;
  } out_item_t;

  // One stored entry of the sorted list.
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        prio;
  } entry_t;

endpackage

[hdl/stable_min_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// Bounded priority queue held as a sorted list in a single-port-write,
// registered-read memory. Equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid / in_stall  in_item   (func, in_data, in_priority)
//  out_      output     out_valid / out_stall out_item (out_data, out_priority,
//                                                       status, fill_count)
//
// One item is worked on at a time. An insert into a non-empty queue walks down
// from the tail, moving up each stored entry with a higher priority value, and a
// remove reads the head and then shifts each remaining entry down one place; an
// insert into an empty queue and refused or empty operations go straight to the
// result. The sequencer returns to idle when the result is loaded, then takes the
// next item. Every shifted entry passes through the entry memory, which does one
// read and one write per cycle.
// Reset empties the queue at once; the memory itself is not cleared.
// A stalled result holds the sequencer in its output state until taken.
//
module stable_min_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  smpq_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output smpq_pkg::out_item_t  out_item
);
  import smpq_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_START     = 7'b0000010,
    S_INS_CMP   = 7'b0000100,
    S_INS_PUT   = 7'b0001000,
    S_REM_HEAD  = 7'b0010000,
    S_REM_SHIFT = 7'b0100000,
    S_OUT       = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  in_item_t            item_r, item_nxt;
  out_item_t           res_r, res_nxt;
  out_item_t           out_r;
  logic                out_load;

  entry_t              mem [CAPACITY];
  entry_t              rd_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_entry;
  entry_t              new_entry;

  logic [CNT_W-1:0]    cnt_inc;
  logic [CNT_W-1:0]    cnt_dec;
  logic [CNT_W-1:0]    idx_m1;
  logic [CNT_W-1:0]    idx_m2;
  logic [CNT_W-1:0]    idx_p1;

  assign cnt_inc   = cnt_r + 1'b1;
  assign cnt_dec   = cnt_r - 1'b1;
  assign idx_m1    = idx_r - 1'b1;
  assign idx_m2    = idx_r - 2'd2;
  assign idx_p1    = idx_r + 1'b1;
  assign new_entry = '{data: item_r.in_data, prio: item_r.in_priority};

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    item_nxt  = item_r;
    res_nxt   = res_r;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_entry  = new_entry;
    out_load  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = S_START;
        end
      end

      S_START: begin
        res_nxt = '{out_data: '0, out_priority: '0, status: STATUS_DONE,
                    fill_count: FILL_W'(cnt_r)};
        if (item_r.func == FUNC_INSERT) begin
          if (cnt_r >= CNT_W'(CAPACITY)) begin
            res_nxt.status = STATUS_FULL;
            state_nxt      = S_OUT;
          end else if (cnt_r == '0) begin
            wr_en              = 1'b1;
            cnt_nxt            = cnt_inc;
            res_nxt.fill_count = FILL_W'(cnt_inc);
            state_nxt          = S_OUT;
          end else begin
            // Walk down from the tail, moving each larger entry up one slot.
            rd_addr   = cnt_dec[IDX_W-1:0];
            idx_nxt   = cnt_r;
            state_nxt = S_INS_CMP;
          end
        end else begin
          if (cnt_r == '0) begin
            res_nxt.status = STATUS_EMPTY;
            state_nxt      = S_OUT;
          end else begin
            rd_addr   = '0;
            state_nxt = S_REM_HEAD;
          end
        end
      end

      S_INS_CMP: begin
        // rd_q holds the entry just below slot idx_r.
        wr_en   = 1'b1;
        wr_addr = idx_r[IDX_W-1:0];
        if (rd_q.prio > item_r.in_priority) begin
          wr_entry = rd_q;
          idx_nxt  = idx_m1;
          if (idx_m1 == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            rd_addr = idx_m2[IDX_W-1:0];
          end
        end else begin
          cnt_nxt            = cnt_inc;
          res_nxt.fill_count = FILL_W'(cnt_inc);
          state_nxt          = S_OUT;
        end
      end

      S_INS_PUT: begin
        wr_en              = 1'b1;
        wr_addr            = '0;
        cnt_nxt            = cnt_inc;
        res_nxt.fill_count = FILL_W'(cnt_inc);
        state_nxt          = S_OUT;
      end

      S_REM_HEAD: begin
        res_nxt.out_data     = rd_q.data;
        res_nxt.out_priority = rd_q.prio;
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt            = cnt_dec;
          res_nxt.fill_count = FILL_W'(cnt_dec);
          state_nxt          = S_OUT;
        end else begin
          rd_addr   = IDX_W'(1);
          idx_nxt   = CNT_W'(1);
          state_nxt = S_REM_SHIFT;
        end
      end

      S_REM_SHIFT: begin
        // rd_q holds slot idx_r; it moves down one place.
        wr_en    = 1'b1;
        wr_addr  = idx_m1[IDX_W-1:0];
        wr_entry = rd_q;
        if (idx_r == cnt_dec) begin
          cnt_nxt            = cnt_dec;
          res_nxt.fill_count = FILL_W'(cnt_dec);
          state_nxt          = S_OUT;
        end else begin
          rd_addr = idx_p1[IDX_W-1:0];
          idx_nxt = idx_p1;
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_q <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_ins_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_CMP) |-> (idx_r != '0 && idx_r <= cnt_r))
    else $error("insert walk index out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the item was finished");

  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == STATUS_EMPTY) |-> (out_item.fill_count == '0))
    else $error("empty status with non-zero fill count");
`endif

endmodule
